// ----- design/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// shared constants for the lfu cache table: field widths, op codes, defaults
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 16;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

endpackage

`default_nettype wire

// ----- design/lfu_victim_sel.sv -----
// ----------------------------------------------------------------------------
// lfu_victim_sel
// replacement search: lowest use count, ties to the least recent entry
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_victim_sel #(
    parameter int MAX_ENTRIES = lfu_pkg::DEFAULT_MAX_ENTRIES,
    parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire logic [MAX_ENTRIES-1:0]   entry_valid,
    input  wire logic [lfu_pkg::CNT_W-1:0] use_counts [MAX_ENTRIES],
    input  wire logic [IDX_W-1:0]         recency_rank [MAX_ENTRIES],
    output logic                          victim_found,
    output logic [IDX_W-1:0]              victim_idx,
    output logic [IDX_W-1:0]              victim_rank
);

    localparam int NP = 1 << IDX_W;

    typedef struct packed {
        logic                      vld;
        logic [lfu_pkg::CNT_W-1:0] cnt;
        logic [IDX_W-1:0]          rank;
        logic [IDX_W-1:0]          idx;
    } node_t;

    node_t nodes [2*NP];

    // a beats b when b is empty, or a has fewer uses, or same uses and is older
    function automatic logic a_wins(input node_t a, input node_t b);
        logic win;
        win = a.vld && (!b.vld || (a.cnt < b.cnt) ||
                        ((a.cnt == b.cnt) && (a.rank > b.rank)));
        return win;
    endfunction

    // binary tree, leaves at NP..2NP-1, root at node 1
    always_comb
    begin
        nodes[0] = '0;
        for (int i = 0; i < NP; i++)
        begin
            if (i < MAX_ENTRIES)
            begin
                nodes[NP+i].vld  = entry_valid[i];
                nodes[NP+i].cnt  = use_counts[i];
                nodes[NP+i].rank = recency_rank[i];
            end
            else
            begin
                nodes[NP+i].vld  = 1'b0;
                nodes[NP+i].cnt  = '0;
                nodes[NP+i].rank = '0;
            end
            nodes[NP+i].idx = IDX_W'(i);
        end
        for (int n = NP - 1; n >= 1; n--)
        begin
            if (a_wins(nodes[2*n], nodes[2*n+1]))
                nodes[n] = nodes[2*n];
            else
                nodes[n] = nodes[2*n+1];
        end
    end

    assign victim_found = nodes[1].vld;
    assign victim_idx   = nodes[1].idx;
    assign victim_rank  = nodes[1].rank;

endmodule

`default_nettype wire

// ----- design/lfu_cache_table.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_table
// key-value cache with least-frequently-used replacement and lru tiebreak
// ----------------------------------------------------------------------------
//
// channel  dir  handshake             payload
// s_*      in   s_tvalid / s_tready   tdata: key, value   tuser: op (0 get, 1 put)
// m_*      out  m_tvalid / m_tready   tdata: read value, evicted key
//                                     tuser: hit, evicted
// cfg_*    in   cfg_valid / cfg_ready cfg_data: capacity in use (always ready)
//
// one beat per cycle sustained while m_tready stays high; a beat is looked up and updated
// while it sits in the input register (key compare, victim tree, write-back), and its
// result is captured in the result register that drives m_tvalid
// reset clears the valid bits and the fill counter; entry arrays are never read
// while invalid, so there is no clearing pass
// m_tready low holds the result; one more beat fills the input register, then s_tready drops
//
`default_nettype none

module lfu_cache_table #(
    parameter int MAX_ENTRIES = lfu_pkg::DEFAULT_MAX_ENTRIES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // tdata: lookup_key [31:0], write_value [63:32]
    input  wire logic [63:0] s_tdata,
    // tuser: op_select [0]
    input  wire logic [0:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,

    // tdata: read_value [31:0], evicted_key [63:32]
    output logic [63:0]      m_tdata,
    // tuser: hit [0], evicted [1]
    output logic [1:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,

    input  wire logic [lfu_pkg::CAP_W-1:0] cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready
);

    localparam int KEY_W  = lfu_pkg::KEY_W;
    localparam int VAL_W  = lfu_pkg::VAL_W;
    localparam int CNT_W  = lfu_pkg::CNT_W;
    localparam int CAP_W  = lfu_pkg::CAP_W;
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FILL_W = IDX_W + 1;
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] cap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= lfu_pkg::CAP_RESET;
        else if (cfg_valid && cfg_ready)
            cap_reg <= cfg_data;
    end

    // capacity above the table size acts as the table size
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] cap_eff;
    assign cap_ext = CMP_W'(cap_reg);
    assign cap_eff = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic                    in_valid_reg;
    logic                    in_op_reg;
    logic signed [KEY_W-1:0] in_key_reg;
    logic signed [VAL_W-1:0] in_val_reg;
    logic                    fire;
    logic                    out_valid_reg;

    // the work stage runs when an item waits and the result slot is free or being emptied
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg  <= s_tuser[0];
            in_key_reg <= s_tdata[KEY_W-1:0];
            in_val_reg <= s_tdata[KEY_W+VAL_W-1:KEY_W];
        end
    end

    // ------------------------------------------------------------------
    // entry state
    // ------------------------------------------------------------------
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [KEY_W-1:0]       key_reg   [MAX_ENTRIES];
    logic [VAL_W-1:0]       value_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]       count_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]       rank_reg  [MAX_ENTRIES];

    // ------------------------------------------------------------------
    // lookup: parallel key compare, one-hot selects
    // ------------------------------------------------------------------
    logic [MAX_ENTRIES-1:0] match;
    logic                   hit_any;
    logic [VAL_W-1:0]       hit_value;
    logic [IDX_W-1:0]       hit_rank;
    logic [IDX_W-1:0]       free_idx;

    always_comb
    begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == in_key_reg);
            if (match[i])
            begin
                hit_value = hit_value | value_reg[i];
                hit_rank  = hit_rank  | rank_reg[i];
            end
        end
        hit_any = |match;
    end

    // lowest-numbered free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx = IDX_W'(i);
        end
    end

    // ------------------------------------------------------------------
    // replacement victim
    // ------------------------------------------------------------------
    logic             victim_found;
    logic [IDX_W-1:0] victim_idx;
    logic [IDX_W-1:0] victim_rank;
    logic [KEY_W-1:0] victim_key;

    lfu_victim_sel #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_victim (
        .entry_valid  (valid_reg),
        .use_counts   (count_reg),
        .recency_rank (rank_reg),
        .victim_found (victim_found),
        .victim_idx   (victim_idx),
        .victim_rank  (victim_rank)
    );

    always_comb
    begin
        victim_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (IDX_W'(i) == victim_idx)
                victim_key = key_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // decision
    // ------------------------------------------------------------------
    logic             is_put;
    logic             put_blocked;
    logic             do_hit;
    logic             do_insert;
    logic             do_evict;
    logic             inc_all;
    logic [IDX_W-1:0] ins_idx;
    logic [IDX_W-1:0] touch_rank;

    assign is_put      = (in_op_reg == lfu_pkg::OP_PUT);
    // zero capacity: a put is dropped, even on a present key
    assign put_blocked = is_put && (cap_eff == '0);
    assign do_hit      = hit_any && !put_blocked;
    assign do_insert   = is_put && !hit_any && !put_blocked;
    // full (or shrunk below fill): replace one entry, fill stays
    assign do_evict    = do_insert && (CMP_W'(fill_reg) >= cap_eff) && victim_found;
    assign inc_all     = do_insert && !do_evict;
    assign ins_idx     = do_evict ? victim_idx : free_idx;
    // entries more recent than the touched one age by one step
    assign touch_rank  = do_hit ? hit_rank : victim_rank;

    // ------------------------------------------------------------------
    // state write-back
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
        end
        else if (fire)
        begin
            if (do_insert)
                valid_reg[ins_idx] <= 1'b1;
            if (inc_all)
                fill_reg <= fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (do_hit && match[i])
                begin
                    if (count_reg[i] != lfu_pkg::CNT_MAX)
                        count_reg[i] <= count_reg[i] + 1'b1;
                    rank_reg[i] <= '0;
                    if (is_put)
                        value_reg[i] <= in_val_reg;
                end
                else if (do_insert && (IDX_W'(i) == ins_idx))
                begin
                    key_reg[i]   <= in_key_reg;
                    value_reg[i] <= in_val_reg;
                    count_reg[i] <= CNT_W'(1);
                    rank_reg[i]  <= '0;
                end
                else if (valid_reg[i] && (do_hit || do_insert) &&
                         (inc_all || (rank_reg[i] < touch_rank)))
                begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic             out_hit_reg;
    logic             out_evicted_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic [KEY_W-1:0] out_evkey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_hit_reg     <= do_hit;
            out_evicted_reg <= do_evict;
            out_value_reg   <= do_hit ? hit_value : '0;
            out_evkey_reg   <= do_evict ? victim_key : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_evkey_reg, out_value_reg};
    assign m_tuser  = {out_evicted_reg, out_hit_reg};

endmodule

`default_nettype wire

// ----- design/lfu_checker.sv -----
// ----------------------------------------------------------------------------
// lfu_checker
// port-level checks on the result stream of the lfu cache table
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic [63:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [4:0]  cfg_data,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // eviction only happens on a miss
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("eviction reported together with a hit");

    // read value is zero on a miss
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero read value on a miss");

    // evicted key is zero when nothing was evicted
    a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[63:32] == 32'd0)
        else $error("nonzero evicted key without eviction");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (.*);

`default_nettype wire

// ----- sim/lfu_table_checker.sv -----
// ----------------------------------------------------------------------------
// lfu_table_checker
// watches the request, reply and capacity channels of the lfu cache table,
// keeps a shadow copy of the table and checks every reply beat against it
// ----------------------------------------------------------------------------

module lfu_table_checker #(
    parameter int SLOTS = lfu_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [63:0]                 s_tdata,
    input  logic [0:0]                  s_tuser,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [63:0]                 m_tdata,
    input  logic [1:0]                  m_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [lfu_pkg::CAP_W-1:0]   cfg_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    output int                          fail_count,
    output int                          requests,
    output int                          replies,
    output int                          hits,
    output int                          evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } cache_reply_t;

    // shadow table, age 0 is the most recently touched entry
    logic [KEY_W-1:0] slot_key   [SLOTS];
    logic [VAL_W-1:0] slot_value [SLOTS];
    logic [CNT_W-1:0] slot_uses  [SLOTS];
    int               slot_age   [SLOTS];
    logic             slot_live  [SLOTS];
    logic [CAP_W-1:0] capacity;

    cache_reply_t pending_replies[$];

    function automatic void promote(int slot);
        int i;
        int old_age;
        old_age = slot_age[slot];
        for (i = 0; i < SLOTS; i++)
            if (slot_live[i] && i != slot && slot_age[i] < old_age)
                slot_age[i]++;
        slot_age[slot] = 0;
    endfunction

    function automatic cache_reply_t apply_request(logic op, logic [KEY_W-1:0] key,
                                                   logic [VAL_W-1:0] value);
        cache_reply_t r;
        int i;
        int limit;
        int found;
        int victim;
        int target;
        int fill;
        int old_age;
        r      = '0;
        found  = -1;
        victim = -1;
        target = -1;
        fill   = 0;
        limit  = (int'(capacity) > SLOTS) ? SLOTS : int'(capacity);

        // no room at all: a put is dropped, even on a present key
        if (op == OP_PUT && limit == 0)
            return r;

        for (i = 0; i < SLOTS; i++)
            if (found < 0 && slot_live[i] && slot_key[i] == key)
                found = i;

        if (found >= 0) begin
            r.hit        = 1'b1;
            r.read_value = slot_value[found];
            if (slot_uses[found] != CNT_MAX)
                slot_uses[found]++;
            promote(found);
            if (op == OP_PUT)
                slot_value[found] = value;
            return r;
        end
        if (op == OP_GET)
            return r;

        for (i = 0; i < SLOTS; i++)
            if (slot_live[i])
                fill++;

        // fewest uses loses, oldest touch breaks the tie
        if (fill >= limit)
            for (i = 0; i < SLOTS; i++)
                if (slot_live[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                    (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
                    victim = i;

        if (victim >= 0) begin
            r.evicted         = 1'b1;
            r.evicted_key     = slot_key[victim];
            slot_live[victim] = 1'b0;
            old_age           = slot_age[victim];
            for (i = 0; i < SLOTS; i++)
                if (slot_live[i] && slot_age[i] > old_age)
                    slot_age[i]--;
            target = victim;
        end else begin
            for (i = 0; i < SLOTS; i++)
                if (target < 0 && !slot_live[i])
                    target = i;
        end
        if (target < 0)
            return r;

        for (i = 0; i < SLOTS; i++)
            if (slot_live[i])
                slot_age[i]++;
        slot_key[target]   = key;
        slot_value[target] = value;
        slot_uses[target]  = 1;
        slot_age[target]   = 0;
        slot_live[target]  = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, cache_reply_t want, cache_reply_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s: expected hit=%0b value=%h evicted=%0b key=%h, got hit=%0b value=%h evicted=%0b key=%h",
                     $time, what, want.hit, want.read_value, want.evicted, want.evicted_key,
                     got.hit, got.read_value, got.evicted, got.evicted_key);
    endtask

    always @(posedge clk) begin : watch
        cache_reply_t want;
        cache_reply_t got;
        int i;
        if (!rst_n) begin
            for (i = 0; i < SLOTS; i++)
                slot_live[i] = 1'b0;
            capacity   = CAP_RESET;
            pending_replies.delete();
            fail_count = 0;
            requests   = 0;
            replies    = 0;
            hits       = 0;
            evictions  = 0;
        end else begin
            // retire the oldest outstanding reply before booking a new request
            if (m_tvalid && m_tready) begin
                got.hit         = m_tuser[0];
                got.read_value  = m_tdata[31:0];
                got.evicted     = m_tuser[1];
                got.evicted_key = m_tdata[63:32];
                replies++;
                if (pending_replies.size() == 0) begin
                    report_mismatch("reply beat with nothing outstanding", '0, got);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.hit !== want.hit || got.read_value !== want.read_value ||
                        got.evicted !== want.evicted || got.evicted_key !== want.evicted_key)
                        report_mismatch("reply beat mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready) begin
                want = apply_request(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);
                requests++;
                if (want.hit)
                    hits++;
                if (want.evicted)
                    evictions++;
                pending_replies.push_back(want);
            end
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
        end
    end

endmodule

// ----- sim/tb_lfu_cache_table.sv -----
// ----------------------------------------------------------------------------
// tb_lfu_cache_table
// drives gets and puts into the lfu cache table under random source gaps and
// sink stalls, steps the capacity through its range while the table is idle,
// and leaves reply checking to lfu_table_checker
// ----------------------------------------------------------------------------

module tb_lfu_cache_table;
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    // generous bound on the run length for ~700 beats
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BEATS = 65;
    localparam int POOL_SIZE   = 24;

    // capacity settings walked by the random part, extremes included:
    // 31 and 17 sit above the table size, 0 disables inserts, and each drop
    // leaves the table fuller than the new capacity
    localparam int NUM_PHASES = 10;
    localparam logic [CAP_W-1:0] PHASE_CAP [NUM_PHASES] =
        '{5'd16, 5'd31, 5'd1, 5'd5, 5'd0, 5'd12, 5'd17, 5'd3, 5'd8, 5'd16};

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic [63:0]         s_tdata   = '0;
    logic [0:0]          s_tuser   = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [63:0]         m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [CAP_W-1:0]    cfg_data  = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;

    // checker results
    int fail_count;
    int requests;
    int replies;
    int hits;
    int evictions;

    // pacing state: burst stretches switch idling off on either side
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;
    int   rx_hold  = 0;

    int               cycle_count = 0;
    int               settings    = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    lfu_cache_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    lfu_table_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_data   (cfg_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .fail_count (fail_count),
        .requests   (requests),
        .replies    (replies),
        .hits       (hits),
        .evictions  (evictions)
    );

    // reply sink: outside a burst stretch, each accepted beat may drop tready for a random hold
    always @(posedge clk)
    begin : sink
        int rx_draw;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end
        else if (rx_hold != 0)
        begin
            rx_hold <= rx_hold - 1;
            if (rx_hold == 1)
                m_tready <= 1'b1;
        end
        else if (m_tvalid && m_tready)
        begin
            if (!rx_burst)
            begin
                rx_draw = $urandom_range(0, 9);
                rx_hold <= rx_draw;
                if (rx_draw != 0)
                    m_tready <= 1'b0;
            end
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on total run length
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d replies outstanding",
                 cycle_count, requests - replies);
        $display("Some tests failed");
        $finish;
    end

    // one request beat: optional gap, then hold tvalid until the handshake
    // tready is looked at on the falling edge so the accepting edge is known
    task automatic send_beat(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= op;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // stop sending and wait until every reply has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (requests != replies)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // capacity writes happen only with the table idle
    task automatic set_capacity(logic [CAP_W-1:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // mostly keys from a small pool so hits, count build-up and evictions
    // are frequent; a share of fully random keys keeps every key bit moving
    function automatic logic [KEY_W-1:0] pick_key(int span);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return $urandom();
        if (roll < 40)
            return key_pool[$urandom_range(0, 3)];
        return key_pool[$urandom_range(0, span - 1)];
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        int phase;
        int n;
        int span;
        logic op;

        for (n = 0; n < POOL_SIZE; n++)
            key_pool[n] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'hffff_ffff;
        key_pool[3] = 32'h0000_0000;

        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset capacity of 16 ----
        send_beat(OP_GET, 32'h0000_0000, 32'h1234_5678);    // miss on an empty table
        send_beat(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);    // extreme key and value
        send_beat(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
        send_beat(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);    // stored -1 must still hit
        send_beat(OP_GET, 32'hffff_ffff, 32'h0000_0000);
        send_beat(OP_GET, 32'h8000_0000, 32'hffff_ffff);
        send_beat(OP_PUT, 32'h7fff_ffff, 32'h0000_0000);    // put on a present key
        send_beat(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
        send_beat(OP_PUT, 32'h0000_0000, 32'h5a5a_5a5a);
        send_beat(OP_GET, 32'h1234_5678, 32'h0000_0000);    // miss with four entries stored

        // zero capacity: puts are dropped even on a present key, gets still hit
        set_capacity(5'd0);
        send_beat(OP_PUT, 32'h8000_0000, 32'h1111_1111);
        send_beat(OP_PUT, 32'h2468_ace0, 32'h0000_0001);
        send_beat(OP_GET, 32'h8000_0000, 32'h0000_0000);

        // capacity below the fill: each new key evicts one, fill stays put
        set_capacity(5'd2);
        send_beat(OP_PUT, 32'h0bad_f00d, 32'hdead_beef);
        send_beat(OP_PUT, 32'h0c0f_fee0, 32'hcafe_babe);
        send_beat(OP_GET, 32'h0c0f_fee0, 32'h0000_0000);

        // ---- random part, one phase per capacity setting ----
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            set_capacity(PHASE_CAP[phase]);
            span = ((PHASE_CAP[phase] > 16) ? 16 : int'(PHASE_CAP[phase])) + 4;
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                // switch pacing mode every few dozen beats
                if (n % 40 == 0)
                begin
                    tx_burst = ($urandom_range(0, 3) == 0);
                    rx_burst <= ($urandom_range(0, 3) == 0);
                end
                op = ($urandom_range(0, 99) < 55) ? OP_PUT : OP_GET;
                send_beat(op, pick_key(span), pick_value());
            end
        end

        drain();
        repeat (10) @(posedge clk);

        $display("%0d request beats and %0d reply beats checked: %0d hits, %0d evictions",
                 requests, replies, hits, evictions);
        $display("%0d capacity writes covering 0, 1, 16 and values above the table size",
                 settings);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
